>>> rtl/cuba_pkg.sv
package cuba_pkg;

    localparam int IDX_W      = 16;   // widest neuron index the tables support
    localparam int NI_W       = 10;   // neuron index width on the ports
    localparam int LANES      = 4;    // input lanes per update request
    localparam int MAX_INPUTS = 4;    // lanes summed at most
    localparam int CNT_MAX    = (MAX_INPUTS < LANES) ? MAX_INPUTS : LANES;

    typedef logic [31:0]      word_t;
    typedef logic [IDX_W-1:0] nidx_t;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_WRITE  = 1'b1;

    localparam logic [2:0] SEL_CURRENT    = 3'd0;
    localparam logic [2:0] SEL_CUR_DECAY  = 3'd1;
    localparam logic [2:0] SEL_WEIGHT     = 3'd2;
    localparam logic [2:0] SEL_VOLT_DECAY = 3'd3;
    localparam logic [2:0] SEL_RESIST     = 3'd4;
    localparam logic [2:0] SEL_THRESH     = 3'd5;
    localparam logic [2:0] SEL_RESET      = 3'd6;
    localparam logic [2:0] SEL_VOLTAGE    = 3'd7;

    typedef struct packed {
        logic                  func;
        nidx_t                 idx;
        logic [2:0]            sel;
        word_t                 val;
        logic [2:0]            cnt;
        word_t [LANES-1:0]     lanes;
    } item_t;

    // one neuron's table words
    typedef struct packed {
        word_t cur;
        word_t volt;
        word_t cdec;
        word_t weight;
        word_t vdec;
        word_t res;
        word_t thr;
        word_t rst;
    } nrn_t;

    // write-back of current and voltage
    typedef struct packed {
        logic  cur_we;
        nidx_t cur_idx;
        word_t cur_data;
        logic  volt_we;
        nidx_t volt_idx;
        word_t volt_data;
    } wb_t;

    // signed value times unsigned u0.32 factor, floor by 2^32
    function automatic word_t decay_mul(input word_t v, input word_t f);
        logic signed [64:0] p;
        p = $signed({v[31], v}) * $signed({1'b0, f});
        return p[63:32];
    endfunction

    // floor by 2^15 of a signed product, saturated to 32 bits
    function automatic word_t sat_q15(input logic [63:0] p);
        if (p[63:46] == {18{p[46]}})
            return p[46:15];
        return p[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage

>>> rtl/cuba_mem.sv
module cuba_mem
    import cuba_pkg::*;
#(
    parameter int NEURONS = 1024
) (
    input  logic  aclk,
    input  logic  rd_en,
    input  nidx_t rd_idx,
    input  logic  pw_en,
    input  logic [2:0] pw_sel,
    input  nidx_t pw_idx,
    input  word_t pw_data,
    input  wb_t   wb,
    input  logic  clr_en,
    input  nidx_t clr_idx,
    output nrn_t  rd_data
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    word_t cur_mem   [NEURONS];
    word_t volt_mem  [NEURONS];
    word_t cdec_mem  [NEURONS];
    word_t wgt_mem   [NEURONS];
    word_t vdec_mem  [NEURONS];
    word_t res_mem   [NEURONS];
    word_t thr_mem   [NEURONS];
    word_t rst_mem   [NEURONS];

    // current and voltage: clear sweep or pipeline write-back
    always_ff @(posedge aclk) begin
        if (clr_en) begin
            cur_mem[clr_idx[AW-1:0]] <= '0;
        end else if (wb.cur_we) begin
            cur_mem[wb.cur_idx[AW-1:0]] <= wb.cur_data;
        end
        if (rd_en) begin
            rd_data.cur <= cur_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            volt_mem[clr_idx[AW-1:0]] <= '0;
        end else if (wb.volt_we) begin
            volt_mem[wb.volt_idx[AW-1:0]] <= wb.volt_data;
        end
        if (rd_en) begin
            rd_data.volt <= volt_mem[rd_idx[AW-1:0]];
        end
    end

    // parameter tables, written straight from write requests
    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_CUR_DECAY) begin
            cdec_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.cdec <= cdec_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_WEIGHT) begin
            wgt_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.weight <= wgt_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_VOLT_DECAY) begin
            vdec_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.vdec <= vdec_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_RESIST) begin
            res_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.res <= res_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_THRESH) begin
            thr_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.thr <= thr_mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en && pw_sel == SEL_RESET) begin
            rst_mem[pw_idx[AW-1:0]] <= pw_data;
        end
        if (rd_en) begin
            rd_data.rst <= rst_mem[rd_idx[AW-1:0]];
        end
    end

endmodule

>>> rtl/cuba_pipe.sv
module cuba_pipe
    import cuba_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  logic  in_valid,
    input  item_t in_item,
    input  nrn_t  rd,
    input  word_t key_base,
    input  nidx_t probe_idx,
    output logic  hazard,
    output wb_t   wb,
    output logic  spike_valid,
    output word_t spike_key,
    output nidx_t spike_idx
);

    // S1: request captured, table words arrive from memory
    logic        v1_reg;
    item_t       it1_reg;
    // S2: decays and input sum
    logic        v2_reg, func2_reg;
    nidx_t       idx2_reg;
    logic [2:0]  sel2_reg;
    word_t       val2_reg, cdc2_reg, vdc2_reg, sum2_reg, w2_reg, res2_reg, thr2_reg, rst2_reg;
    // S3: sum times weight
    logic        v3_reg, func3_reg;
    nidx_t       idx3_reg;
    logic [2:0]  sel3_reg;
    word_t       val3_reg, cdc3_reg, vdc3_reg, res3_reg, thr3_reg, rst3_reg;
    logic [63:0] p1_3_reg;
    // S4: new current
    logic        v4_reg, func4_reg;
    nidx_t       idx4_reg;
    logic [2:0]  sel4_reg;
    word_t       val4_reg, cur4_reg, vdc4_reg, res4_reg, thr4_reg, rst4_reg;
    // S5: current times resistance
    logic        v5_reg, func5_reg;
    nidx_t       idx5_reg;
    logic [2:0]  sel5_reg;
    word_t       val5_reg, vdc5_reg, thr5_reg, rst5_reg;
    logic [63:0] p2_5_reg;

    logic [2:0]  cnt_lim;
    word_t       sum_next;
    word_t       cur_new, volt_new;
    logic        fire;

    always_comb begin
        cnt_lim  = (it1_reg.cnt > 3'(CNT_MAX)) ? 3'(CNT_MAX) : it1_reg.cnt;
        sum_next = '0;
        for (int k = 0; k < LANES; k++) begin
            if (3'(k) < cnt_lim)
                sum_next = sum_next + it1_reg.lanes[k];
        end
    end

    assign cur_new  = cdc3_reg + sat_q15(p1_3_reg);
    assign volt_new = vdc5_reg + sat_q15(p2_5_reg);
    assign fire     = $signed(volt_new) >= $signed(thr5_reg);

    always_comb begin
        wb.cur_we    = adv && v3_reg && (func3_reg == FUNC_UPDATE || sel3_reg == SEL_CURRENT);
        wb.cur_idx   = idx3_reg;
        wb.cur_data  = (func3_reg == FUNC_WRITE) ? val3_reg : cur_new;
        wb.volt_we   = adv && v5_reg && (func5_reg == FUNC_UPDATE || sel5_reg == SEL_VOLTAGE);
        wb.volt_idx  = idx5_reg;
        if (func5_reg == FUNC_WRITE)
            wb.volt_data = val5_reg;
        else
            wb.volt_data = fire ? rst5_reg : volt_new;
    end

    assign spike_valid = v5_reg && func5_reg == FUNC_UPDATE && fire;
    assign spike_key   = key_base + 32'(idx5_reg);
    assign spike_idx   = idx5_reg;

    // same neuron still in flight: hold the next request back
    assign hazard = (v1_reg && it1_reg.idx == probe_idx) || (v2_reg && idx2_reg == probe_idx)
                 || (v3_reg && idx3_reg == probe_idx) || (v4_reg && idx4_reg == probe_idx)
                 || (v5_reg && idx5_reg == probe_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg   <= in_item;

            func2_reg <= it1_reg.func;
            idx2_reg  <= it1_reg.idx;
            sel2_reg  <= it1_reg.sel;
            val2_reg  <= it1_reg.val;
            cdc2_reg  <= decay_mul(rd.cur, rd.cdec);
            vdc2_reg  <= decay_mul(rd.volt, rd.vdec);
            sum2_reg  <= sum_next;
            w2_reg    <= rd.weight;
            res2_reg  <= rd.res;
            thr2_reg  <= rd.thr;
            rst2_reg  <= rd.rst;

            func3_reg <= func2_reg;
            idx3_reg  <= idx2_reg;
            sel3_reg  <= sel2_reg;
            val3_reg  <= val2_reg;
            cdc3_reg  <= cdc2_reg;
            vdc3_reg  <= vdc2_reg;
            p1_3_reg  <= 64'($signed(sum2_reg) * $signed(w2_reg));
            res3_reg  <= res2_reg;
            thr3_reg  <= thr2_reg;
            rst3_reg  <= rst2_reg;

            func4_reg <= func3_reg;
            idx4_reg  <= idx3_reg;
            sel4_reg  <= sel3_reg;
            val4_reg  <= val3_reg;
            cur4_reg  <= cur_new;
            vdc4_reg  <= vdc3_reg;
            res4_reg  <= res3_reg;
            thr4_reg  <= thr3_reg;
            rst4_reg  <= rst3_reg;

            func5_reg <= func4_reg;
            idx5_reg  <= idx4_reg;
            sel5_reg  <= sel4_reg;
            val5_reg  <= val4_reg;
            vdc5_reg  <= vdc4_reg;
            p2_5_reg  <= 64'($signed(cur4_reg) * $signed(res4_reg));
            thr5_reg  <= thr4_reg;
            rst5_reg  <= rst4_reg;
        end
    end

endmodule

>>> rtl/cuba_lif_neuron_update_top.sv
// Path: an accepted request passes five pipe stages (the first one loaded with the
// memory read), then the output register, before its spike shows on m_tvalid.
// Throughput: one request per cycle while the output register can take; a request
// for a neuron still in the pipe waits until the earlier request on it has written back.
// Reset: aresetn synchronous, active low. After reset a sweep clears the current and
// voltage tables, s_tready low meanwhile; the config port stays open.
// The other parameter tables are not cleared.
module cuba_lif_neuron_update_top
    import cuba_pkg::*;
#(
    parameter int NEURONS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config: spike_key_base
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // requests in
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: neuron_index[9:0], param_select[12:10], param_value[44:13], input_count[47:45],
    //        input_0[79:48], input_1[111:80], input_2[143:112], input_3[175:144]
    input  logic [175:0] s_tdata,
    // tuser: func[0]
    input  logic [0:0]   s_tuser,
    // spikes out
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: spike_key[31:0], fired_index[41:32], zero[47:42]
    output logic [47:0]  m_tdata
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    logic          clr_reg, clr_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    word_t         base_reg;
    logic          out_valid_reg, out_valid_next;
    word_t         out_key_reg;
    nidx_t         out_idx_reg;

    item_t  item;
    logic   in_range, accept, adv, hazard;
    nrn_t   rd_data;
    wb_t    wb;
    logic   spike_valid;
    word_t  spike_key;
    nidx_t  spike_idx;

    // unpack request
    always_comb begin
        item.func  = s_tuser[0];
        item.idx   = IDX_W'(s_tdata[9:0]);
        item.sel   = s_tdata[12:10];
        item.val   = s_tdata[44:13];
        item.cnt   = s_tdata[47:45];
        item.lanes[0] = s_tdata[79:48];
        item.lanes[1] = s_tdata[111:80];
        item.lanes[2] = s_tdata[143:112];
        item.lanes[3] = s_tdata[175:144];
    end

    // indexes beyond the table are taken and dropped
    assign in_range = 32'(item.idx) < 32'(NEURONS);

    // whole pipe moves when the output register can take
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !hazard && !clr_reg;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            base_reg <= cfg_data;
        end
    end

    // clear sweep over current and voltage tables
    always_comb begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(NEURONS - 1))
                clr_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    cuba_mem #(
        .NEURONS (NEURONS)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_idx  (item.idx),
        .pw_en   (accept && in_range && item.func == FUNC_WRITE),
        .pw_sel  (item.sel),
        .pw_idx  (item.idx),
        .pw_data (item.val),
        .wb      (wb),
        .clr_en  (clr_reg),
        .clr_idx (IDX_W'(clr_cnt_reg)),
        .rd_data (rd_data)
    );

    cuba_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (accept && in_range),
        .in_item     (item),
        .rd          (rd_data),
        .key_base    (base_reg),
        .probe_idx   (item.idx),
        .hazard      (hazard),
        .wb          (wb),
        .spike_valid (spike_valid),
        .spike_key   (spike_key),
        .spike_idx   (spike_idx)
    );

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = spike_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && spike_valid) begin
            out_key_reg <= spike_key;
            out_idx_reg <= spike_idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_idx_reg[NI_W-1:0], out_key_reg};

endmodule

>>> rtl/cuba_checker.sv
module cuba_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);

    // table clear runs right after reset
    a_clr_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("request taken during table clear");

    a_out_idle_after_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("spike valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("spike dropped under backpressure");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("spike data changed under backpressure");

endmodule

bind cuba_lif_neuron_update_top cuba_checker u_cuba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
